@@ design/assert_macros.svh @@
// Assertion macros, included by the datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge out of reset.
`define ASSERT_AT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// Consequence that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_AT(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ design/ncq_pkg.sv @@
// Package with item types, datapath commands, status and the CDF table.
package ncq_pkg;

	localparam int unsigned FracBits = 16;
	localparam int unsigned RomSize  = 400;
	localparam logic [16:0] OneQ16   = 17'd65536;
	localparam logic [16:0] HalfQ16  = 17'd32768;
	localparam logic [24:0] TopU     = 25'(399 << FracBits);
	localparam logic [8:0]  RomLast  = 9'(RomSize);

	// Register indexes of the configuration port.
	localparam logic [1:0] RegMean = 2'd0;
	localparam logic [1:0] RegStd  = 2'd1;

	typedef struct packed {
		logic        kind;
		logic [31:0] x_in;
		logic [16:0] prob_in;
	} in_item_t;

	typedef struct packed {
		logic [31:0] x_out;
		logic [16:0] prob_out;
		logic        saturated;
	} out_item_t;

	// Datapath operations, one per cycle.
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_PREP,
		OP_MUL100,
		OP_DIVLD_K0,
		OP_DIV_STEP,
		OP_K0U,
		OP_RD0,
		OP_RD1,
		OP_RD2,
		OP_K0FIN,
		OP_STEP,
		OP_SRCH_RD,
		OP_SRCH_CMP,
		OP_K1E,
		OP_K1U,
		OP_MULA,
		OP_MULB,
		OP_SUM,
		OP_DIV100_A,
		OP_DIV100_B,
		OP_K1FIN,
		OP_RES
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic kind;
		logic sd_zero;
		logic ovf;
		logic div_done;
		logic srch_done;
		logic e_zero;
		logic e_full;
		logic res_free;
	} stat_t;

	// Standard normal CDF for z = 0.00 .. 3.99, four decimals times 10000.
	localparam logic [13:0] CDF_DEC [0:399] = '{
		5000,5040,5080,5120,5160,5199,5239,5279,5319,5359,
		5398,5438,5478,5517,5557,5596,5636,5675,5714,5753,
		5793,5832,5871,5910,5948,5987,6026,6064,6103,6141,
		6179,6217,6255,6293,6331,6368,6406,6443,6480,6517,
		6554,6591,6628,6664,6700,6736,6772,6808,6844,6879,
		6915,6950,6985,7019,7054,7088,7123,7157,7190,7224,
		7257,7291,7324,7357,7389,7422,7454,7486,7517,7549,
		7580,7611,7642,7673,7704,7734,7764,7794,7823,7852,
		7881,7910,7939,7967,7995,8023,8051,8078,8106,8133,
		8159,8186,8212,8238,8264,8289,8315,8340,8365,8389,
		8413,8438,8461,8485,8508,8531,8554,8577,8599,8621,
		8643,8665,8686,8708,8729,8749,8770,8790,8810,8830,
		8849,8869,8888,8907,8925,8944,8962,8980,8997,9015,
		9032,9049,9066,9082,9099,9115,9131,9147,9162,9177,
		9192,9207,9222,9236,9251,9265,9279,9292,9306,9319,
		9332,9345,9357,9370,9382,9394,9406,9418,9429,9441,
		9452,9463,9474,9484,9495,9505,9515,9525,9535,9545,
		9554,9564,9573,9582,9591,9599,9608,9616,9625,9633,
		9641,9649,9656,9664,9671,9678,9686,9693,9699,9706,
		9713,9719,9726,9732,9738,9744,9750,9756,9761,9767,
		9772,9778,9783,9788,9793,9798,9803,9808,9812,9817,
		9821,9826,9830,9834,9838,9842,9846,9850,9854,9857,
		9861,9864,9868,9871,9875,9878,9881,9884,9887,9890,
		9893,9896,9898,9901,9904,9906,9909,9911,9913,9916,
		9918,9920,9922,9925,9927,9929,9931,9932,9934,9936,
		9938,9940,9941,9943,9945,9946,9948,9949,9951,9952,
		9953,9955,9956,9957,9959,9960,9961,9962,9963,9964,
		9965,9966,9967,9968,9969,9970,9971,9972,9973,9974,
		9974,9975,9976,9977,9977,9978,9979,9979,9980,9981,
		9981,9982,9982,9983,9984,9984,9985,9985,9986,9986,
		9987,9987,9987,9988,9988,9989,9989,9989,9990,9990,
		9990,9991,9991,9991,9992,9992,9992,9992,9993,9993,
		9993,9993,9994,9994,9994,9994,9994,9995,9995,9995,
		9995,9995,9995,9996,9996,9996,9996,9996,9996,9997,
		9997,9997,9997,9997,9997,9997,9997,9997,9997,9998,
		9998,9998,9998,9998,9998,9998,9998,9998,9998,9998,
		9998,9998,9999,9999,9999,9999,9999,9999,9999,9999,
		9999,9999,9999,9999,9999,9999,9999,9999,9999,9999,
		9999,9999,9999,9999,9999,9999,9999,9999,9999,9999,
		10000,10000,10000,10000,10000,10000,10000,10000,10000,10000
	};

	// Table entry in Q1.16, rounded to nearest; past the end reads as 1.0.
	// The division by 10000 is a shift by four and a reciprocal multiply for 625.
	function automatic logic [16:0] rom_val(input logic [8:0] idx);
		logic [29:0] scaled;
		logic [52:0] recip;
		if (idx >= RomLast) begin
			return OneQ16;
		end
		scaled = 30'(CDF_DEC[idx]) * 30'd65536 + 30'd5000;
		recip  = 53'(scaled[29:4]) * 53'd109951163;
		return recip[52:36];
	endfunction

endpackage

@@ design/ncq_datapath.sv @@
// Datapath: configuration registers, table, shared divider, multipliers, result register.
`include "assert_macros.svh"
module ncq_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  ncq_pkg::cmd_t      cmd,
	output ncq_pkg::stat_t     stat,
	input  ncq_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output ncq_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import ncq_pkg::*;

	logic        kind_q;
	logic [31:0] x_q;
	logic [16:0] pin_q;
	logic [31:0] mean_q;
	logic [31:0] sd_q;
	logic        neg_q;
	logic [32:0] ad_q;
	logic [16:0] q_q;
	logic [38:0] m_q;
	logic [8:0]  lo_q;
	logic [8:0]  hi_q;
	logic [24:0] u_q;
	logic        sat_q;
	logic [16:0] rom_data_q;
	logic [16:0] v0_q;
	logic [32:0] prod_q;
	logic [40:0] a_q;
	logic [47:0] b_q;
	logic [31:0] rem_q;
	logic [41:0] nsh_q;
	logic [41:0] quot_q;
	logic [31:0] dvs_q;
	logic [5:0]  cnt_q;
	logic [16:0] prob_q;
	logic [31:0] xres_q;
	out_item_t   res_q;
	logic        res_valid_q;

	logic [33:0] diff;
	logic [33:0] absd;
	logic [16:0] pclip;
	logic [9:0]  mid_sum;
	logic [8:0]  mid;
	logic [8:0]  rom_addr;
	logic [32:0] r2;
	logic        ge;
	logic [32:0] r2_sub;
	logic [16:0] qdiff;
	logic [41:0] sum42;
	logic [33:0] interp;
	logic [16:0] pval;
	logic [37:0] xr;
	logic [52:0] recip100;

	// Deviation from the mean, its magnitude, and probability clipping.
	always_comb begin
		diff  = 34'($signed(x_q)) - 34'($signed(mean_q));
		absd  = diff[33] ? (34'd0 - diff) : diff;
		pclip = (pin_q > OneQ16) ? OneQ16 : pin_q;
	end

	// Search midpoint and table address.
	always_comb begin
		mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
		mid     = mid_sum[9:1];
		case (cmd.op)
			OP_SRCH_RD: rom_addr = mid;
			OP_RD0:     rom_addr = kind_q ? (lo_q - 9'd1) : u_q[24:16];
			OP_RD1:     rom_addr = kind_q ? lo_q : (u_q[24:16] + 9'd1);
			default:    rom_addr = '0;
		endcase
	end

	// One restoring divider step.
	always_comb begin
		r2     = {rem_q, nsh_q[41]};
		ge     = r2 >= {1'b0, dvs_q};
		r2_sub = r2 - {1'b0, dvs_q};
	end

	// Operand forming for divider loads and the final sums.
	always_comb begin
		qdiff    = q_q - v0_q;
		sum42    = 42'(a_q) + 42'(b_q[47:16]);
		interp   = 34'(v0_q) + ((34'(prod_q) + 34'd32768) >> 16);
		pval     = (u_q[24:16] >= 9'd399) ? OneQ16 : interp[16:0];
		xr       = neg_q ? (38'($signed(mean_q)) - 38'(quot_q[35:0]))
		                 : (38'($signed(mean_q)) + 38'(quot_q[35:0]));
		// Low part of the division by 100: multiply by the rounded-up reciprocal.
		recip100 = 53'(rem_q[26:0]) * 53'd42949673;
	end

	// Status toward the controller.
	always_comb begin
		stat.kind      = kind_q;
		stat.sd_zero   = (sd_q == '0);
		stat.ovf       = ({2'b0, m_q[38:9]} >= sd_q);
		stat.div_done  = (cnt_q == '0);
		stat.srch_done = (lo_q >= hi_q);
		stat.e_zero    = (lo_q == '0);
		stat.e_full    = (lo_q == RomLast);
		stat.res_free  = !res_valid_q || out_ready;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q <= '0;
			sd_q   <= 32'd65536;
		end else if (cfg_valid) begin
			if (cfg_index == RegMean) begin
				mean_q <= cfg_data;
			end else if (cfg_index == RegStd) begin
				sd_q <= cfg_data;
			end
		end
	end

	// Control registers: divider count and result handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_DIVLD_K0: cnt_q <= stat.ovf ? 6'd0 : 6'd25;
				OP_RD2:      cnt_q <= kind_q ? 6'd25 : 6'd0;
				OP_DIV_STEP: cnt_q <= cnt_q - 6'd1;
				default:     cnt_q <= cnt_q;
			endcase
			if (cmd.op == OP_RES) begin
				res_valid_q <= 1'b1;
			end else if (out_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Table read, registered.
	always_ff @(posedge clk) begin
		rom_data_q <= rom_val(rom_addr);
	end

	// Payload registers, one operation per cycle.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				kind_q <= in_data.kind;
				x_q    <= in_data.x_in;
				pin_q  <= in_data.prob_in;
			end
			OP_PREP: begin
				sat_q <= 1'b0;
				lo_q  <= '0;
				hi_q  <= RomLast;
				if (kind_q) begin
					neg_q <= pclip < HalfQ16;
					q_q   <= (pclip < HalfQ16) ? (OneQ16 - pclip) : pclip;
				end else begin
					neg_q <= diff[33];
					ad_q  <= absd[32:0];
				end
			end
			OP_MUL100: m_q <= 39'(ad_q) * 39'd100;
			OP_DIVLD_K0: begin
				if (stat.ovf) begin
					quot_q <= 42'(TopU);
					sat_q  <= 1'b1;
				end else begin
					quot_q <= '0;
				end
				rem_q <= {2'b0, m_q[38:9]};
				nsh_q <= {m_q[8:0], 33'd0};
				dvs_q <= sd_q;
			end
			OP_DIV_STEP: begin
				rem_q  <= ge ? r2_sub[31:0] : r2[31:0];
				nsh_q  <= {nsh_q[40:0], 1'b0};
				quot_q <= {quot_q[40:0], ge};
			end
			OP_K0U: begin
				if (quot_q > 42'(TopU)) begin
					u_q   <= TopU;
					sat_q <= 1'b1;
				end else begin
					u_q <= quot_q[24:0];
				end
			end
			OP_RD1: v0_q <= rom_data_q;
			OP_RD2: begin
				if (kind_q) begin
					quot_q <= '0;
					rem_q  <= {24'd0, qdiff[16:9]};
					nsh_q  <= {qdiff[8:0], 33'd0};
					dvs_q  <= {15'd0, rom_data_q - v0_q};
				end else begin
					prod_q <= 33'(rom_data_q - v0_q) * 33'(u_q[15:0]);
				end
			end
			OP_K0FIN: prob_q <= neg_q ? (OneQ16 - pval) : pval;
			OP_STEP:  prob_q <= neg_q ? 17'd0 : OneQ16;
			OP_SRCH_CMP: begin
				if (rom_data_q >= q_q) begin
					hi_q <= mid;
				end else begin
					lo_q <= mid + 9'd1;
				end
			end
			OP_K1E: begin
				if (lo_q == '0) begin
					u_q <= '0;
				end else if (lo_q == RomLast) begin
					u_q <= TopU;
				end
			end
			OP_K1U:  u_q <= {lo_q - 9'd1, 16'd0} + quot_q[24:0];
			OP_MULA: a_q <= 41'(u_q[24:16]) * 41'(sd_q);
			OP_MULB: b_q <= 48'(u_q[15:0]) * 48'(sd_q);
			OP_SUM:  nsh_q <= sum42;
			// Division by 100: split at bit 21, since 2^21 = 100 * 20971 + 52.
			OP_DIV100_A: begin
				quot_q <= 42'(nsh_q[40:21]) * 42'd20971;
				rem_q  <= 32'(27'(nsh_q[40:21]) * 27'd52 + 27'(nsh_q[20:0]));
			end
			OP_DIV100_B: quot_q <= quot_q + 42'(recip100[52:32]);
			OP_K1FIN: begin
				if ($signed(xr) > 38'sd2147483647) begin
					xres_q <= 32'h7FFF_FFFF;
					sat_q  <= 1'b1;
				end else if ($signed(xr) < -38'sd2147483648) begin
					xres_q <= 32'h8000_0000;
					sat_q  <= 1'b1;
				end else begin
					xres_q <= xr[31:0];
				end
			end
			OP_RES: begin
				res_q.x_out     <= kind_q ? xres_q : 32'd0;
				res_q.prob_out  <= kind_q ? 17'd0 : prob_q;
				res_q.saturated <= sat_q;
			end
			default: begin
			end
		endcase
	end

	assign out_valid = res_valid_q;
	assign out_data  = res_q;

	`ASSERT_AT(a_res_no_overwrite, clk, arst_n, (cmd.op == OP_RES) |-> (!res_valid_q || out_ready))
	`ASSERT_AT(a_div_count, clk, arst_n, (cmd.op == OP_DIV_STEP) |-> (cnt_q != 6'd0))
	`ASSERT_NEXT(a_u_range, clk, arst_n, (cmd.op == OP_K0U || cmd.op == OP_K1U), (u_q <= TopU))
endmodule

@@ design/ncq_ctrl.sv @@
// Controller state machine sequencing the datapath operations.
module ncq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ncq_pkg::stat_t stat,
	output ncq_pkg::cmd_t  cmd
);
	import ncq_pkg::*;

	typedef enum logic [21:0] {
		S_IDLE  = 22'h000001,
		S_PREP  = 22'h000002,
		S_K0MUL = 22'h000004,
		S_K0CHK = 22'h000008,
		S_DIV   = 22'h000010,
		S_K0U   = 22'h000020,
		S_RD0   = 22'h000040,
		S_RD1   = 22'h000080,
		S_RD2   = 22'h000100,
		S_K0FIN = 22'h000200,
		S_STEP  = 22'h000400,
		S_SRCHA = 22'h000800,
		S_SRCHB = 22'h001000,
		S_K1E   = 22'h002000,
		S_K1U   = 22'h004000,
		S_MULA  = 22'h008000,
		S_MULB  = 22'h010000,
		S_SUM   = 22'h020000,
		S_D100A = 22'h040000,
		S_D100B = 22'h080000,
		S_K1FIN = 22'h100000,
		S_RES   = 22'h200000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == S_IDLE);

	// Next state and the operation issued in each state.
	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				cmd.op = OP_PREP;
				if (stat.kind) begin
					state_d = S_SRCHA;
				end else begin
					state_d = stat.sd_zero ? S_STEP : S_K0MUL;
				end
			end
			S_K0MUL: begin
				cmd.op  = OP_MUL100;
				state_d = S_K0CHK;
			end
			S_K0CHK: begin
				cmd.op  = OP_DIVLD_K0;
				state_d = stat.ovf ? S_K0U : S_DIV;
			end
			S_DIV: begin
				if (stat.div_done) begin
					state_d = stat.kind ? S_K1U : S_K0U;
				end else begin
					cmd.op = OP_DIV_STEP;
				end
			end
			S_K0U: begin
				cmd.op  = OP_K0U;
				state_d = S_RD0;
			end
			S_RD0: begin
				cmd.op  = OP_RD0;
				state_d = S_RD1;
			end
			S_RD1: begin
				cmd.op  = OP_RD1;
				state_d = S_RD2;
			end
			S_RD2: begin
				cmd.op  = OP_RD2;
				state_d = stat.kind ? S_DIV : S_K0FIN;
			end
			S_K0FIN: begin
				cmd.op  = OP_K0FIN;
				state_d = S_RES;
			end
			S_STEP: begin
				cmd.op  = OP_STEP;
				state_d = S_RES;
			end
			S_SRCHA: begin
				if (stat.srch_done) begin
					state_d = S_K1E;
				end else begin
					cmd.op  = OP_SRCH_RD;
					state_d = S_SRCHB;
				end
			end
			S_SRCHB: begin
				cmd.op  = OP_SRCH_CMP;
				state_d = S_SRCHA;
			end
			S_K1E: begin
				cmd.op  = OP_K1E;
				state_d = (stat.e_zero || stat.e_full) ? S_MULA : S_RD0;
			end
			S_K1U: begin
				cmd.op  = OP_K1U;
				state_d = S_MULA;
			end
			S_MULA: begin
				cmd.op  = OP_MULA;
				state_d = S_MULB;
			end
			S_MULB: begin
				cmd.op  = OP_MULB;
				state_d = S_SUM;
			end
			S_SUM: begin
				cmd.op  = OP_SUM;
				state_d = S_D100A;
			end
			S_D100A: begin
				cmd.op  = OP_DIV100_A;
				state_d = S_D100B;
			end
			S_D100B: begin
				cmd.op  = OP_DIV100_B;
				state_d = S_K1FIN;
			end
			S_K1FIN: begin
				cmd.op  = OP_K1FIN;
				state_d = S_RES;
			end
			S_RES: begin
				if (stat.res_free) begin
					cmd.op  = OP_RES;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

@@ design/normal_cdf_and_quantile.sv @@
// Top level of the normal CDF and quantile block.
// One item at a time. A CDF item (kind 0) runs a 25-step restoring division for the z
// quotient, then the table-read states RD0, RD1 and RD2 and the interpolation; when the
// quotient clips, the division is skipped, and a zero standard deviation gives the step
// result. A quantile item (kind 1) runs a binary search of the 400-entry table, each
// step a table read and a compare (8 or 9 steps), a 25-step division for the
// interpolation weight, two multiplies and a division by 100 done by reciprocal
// multiplication in the states D100A and D100B; when the search ends at the first entry
// or past the last, the table reads and the division are skipped. The next item is
// accepted in the cycle after a result is written, even while that result still waits
// in the output register; only a result that is not yet taken holds the next one back.
// Configuration writes are always taken and must only be issued while the block is idle.
module normal_cdf_and_quantile (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ncq_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output ncq_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import ncq_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// Registers are written in any cycle.
	assign cfg_ready = 1'b1;

	ncq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ncq_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);
endmodule
